>>> hdl/pat_pkg.sv
package pat_pkg;

    // Field widths.
    localparam int ACTION_W  = 2;
    localparam int TIME_W    = 32;
    localparam int VALUE_W   = 10;
    localparam int DIVIDER_W = 8;
    localparam int FAIL_W    = 4;
    localparam int BLINK_W   = 3;

    // Configuration port.
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYNC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd2;

    // Register reset values.
    localparam logic [VALUE_W-1:0]   SYNC_RESET    = 10'd999;
    localparam logic [VALUE_W-1:0]   DISABLE_RESET = 10'd998;
    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd1;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REJECT = 2'd2;

    // Digit-serial datapath: 4-bit digits, least significant first.
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = TIME_W / DIGIT_W;

    // Credit in seconds: value * 86400 fits in 27 bits.
    localparam int CREDIT_W = 27;
    localparam int CNT_W    = $clog2(CREDIT_W);
    localparam int DAY_W    = 17;
    localparam logic [DAY_W-1:0] SECONDS_PER_DAY = 17'(3600 * 24);

    // Failure lockout.
    localparam logic [FAIL_W-1:0] FAIL_CAP  = 4'd9;
    localparam logic [TIME_W-1:0] LOCK_BASE = 32'd60;

    // Blink codes.
    localparam logic [BLINK_W-1:0] BLINK_NONE    = 3'd0;
    localparam logic [BLINK_W-1:0] BLINK_CREDIT  = 3'd2;
    localparam logic [BLINK_W-1:0] BLINK_SYNC    = 3'd3;
    localparam logic [BLINK_W-1:0] BLINK_DISABLE = 3'd5;

    // What the current request does.
    typedef enum logic [2:0] {
        KIND_QUERY,
        KIND_REJECT,
        KIND_SYNC,
        KIND_DISABLE,
        KIND_CREDIT
    } pat_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD,
        ST_DONE
    } pat_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   now_seconds;
        logic [VALUE_W-1:0]  token_value;
        logic                count_is_odd;
    } pat_in_t;

    typedef struct packed {
        logic               active;
        logic               entry_allowed;
        logic [BLINK_W-1:0] blink_count;
        logic               store_request;
        logic [FAIL_W-1:0]  failure_level;
    } pat_out_t;

endpackage

>>> hdl/prepaid_activation_timer.sv
// Prepaid activation timer. Each request carries the current time and a status query, an
// accepted token or a rejected token; each request yields exactly one result. A request is
// taken only in the idle state and passes through the divide, add and done states before
// the next one is taken: the bit-serial restoring divider turns value * 86400 into seconds of
// credit (one quotient bit per cycle, in parallel with a digit-serial compare of the old expiry
// against the current time), the 4-bit digit-serial adder and comparators update the expiry or
// lockout time, the result is handed to the output register, and the block returns to idle,
// where the next request is taken.
// The output register lets a new request enter while the previous result still waits; that
// request then holds in its last cycle until the output register is free.
// Configuration writes are applied at once and must only be made while the block is idle.
module prepaid_activation_timer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pat_pkg::pat_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pat_pkg::pat_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pat_pkg::CFG_W-1:0]     cfg_wdata
);
    import pat_pkg::*;

    // Control state.
    pat_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    pat_kind_t kind_reg, kind_next;
    logic odd_reg, odd_next;
    logic m_valid_reg, m_valid_next;

    // Configuration registers.
    logic [VALUE_W-1:0]   sync_reg, sync_next;
    logic [VALUE_W-1:0]   disable_reg, disable_next;
    logic [DIVIDER_W-1:0] divider_reg, divider_next;

    // Persistent state.
    logic [FAIL_W-1:0] fail_reg, fail_next;
    logic [TIME_W-1:0] lock_reg, lock_next;
    logic [TIME_W-1:0] expiry_reg, expiry_next;
    logic              meter_reg, meter_next;

    // Datapath.
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [CREDIT_W-1:0]  dvd_reg, dvd_next;
    logic [DIVIDER_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0]    addend_reg, addend_next;
    logic                 carry_reg, carry_next;
    logic                 exp_lt_reg, exp_lt_next;
    logic                 exp_gt_reg, exp_gt_next;
    logic                 lock_gt_reg, lock_gt_next;
    pat_out_t             m_data_reg, m_data_next;

    logic [DIVIDER_W-1:0] divisor;
    logic [DIVIDER_W:0]   trial;
    logic                 trial_ge;
    logic [TIME_W-1:0]    lock_addend;
    logic [DIGIT_W-1:0]   now_d, exp_d, lock_d, add_d, base_d, new_exp_d, new_lock_d;
    logic [DIGIT_W:0]     sum_d;

    // A divider of zero counts as one.
    assign divisor = (divider_reg == '0) ? DIVIDER_W'(1) : divider_reg;

    // One restoring division step.
    assign trial    = {rem_reg, dvd_reg[CREDIT_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor});

    // Lockout length after the failure count has been updated.
    assign lock_addend = LOCK_BASE << fail_reg;

    // Digit-serial add: the lowest digits of the rotating registers.
    assign now_d  = now_reg[DIGIT_W-1:0];
    assign exp_d  = expiry_reg[DIGIT_W-1:0];
    assign lock_d = lock_reg[DIGIT_W-1:0];
    assign add_d  = addend_reg[DIGIT_W-1:0];

    // Set time starts from now; add time starts from the later of now and the old expiry.
    always_comb begin
        if (kind_reg == KIND_REJECT || odd_reg || exp_lt_reg) begin
            base_d = now_d;
        end else begin
            base_d = exp_d;
        end
    end

    assign sum_d      = {1'b0, base_d} + {1'b0, add_d} + {{DIGIT_W{1'b0}}, carry_reg};
    assign new_exp_d  = (kind_reg == KIND_CREDIT) ? sum_d[DIGIT_W-1:0] : exp_d;
    assign new_lock_d = (kind_reg == KIND_REJECT) ? sum_d[DIGIT_W-1:0] : lock_d;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // State register and the other registers that have a reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            kind_reg    <= KIND_QUERY;
            m_valid_reg <= 1'b0;
            sync_reg    <= SYNC_RESET;
            disable_reg <= DISABLE_RESET;
            divider_reg <= DIVIDER_RESET;
            fail_reg    <= '0;
            lock_reg    <= '0;
            expiry_reg  <= '0;
            meter_reg   <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
            sync_reg    <= sync_next;
            disable_reg <= disable_next;
            divider_reg <= divider_next;
            fail_reg    <= fail_next;
            lock_reg    <= lock_next;
            expiry_reg  <= expiry_next;
            meter_reg   <= meter_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        odd_reg     <= odd_next;
        now_reg     <= now_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        addend_reg  <= addend_next;
        carry_reg   <= carry_next;
        exp_lt_reg  <= exp_lt_next;
        exp_gt_reg  <= exp_gt_next;
        lock_gt_reg <= lock_gt_next;
        m_data_reg  <= m_data_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        kind_next    = kind_reg;
        odd_next     = odd_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        sync_next    = sync_reg;
        disable_next = disable_reg;
        divider_next = divider_reg;
        fail_next    = fail_reg;
        lock_next    = lock_reg;
        expiry_next  = expiry_reg;
        meter_next   = meter_reg;
        now_next     = now_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        addend_next  = addend_reg;
        carry_next   = carry_reg;
        exp_lt_next  = exp_lt_reg;
        exp_gt_next  = exp_gt_reg;
        lock_gt_next = lock_gt_reg;
        m_data_next  = m_data_reg;

        // Configuration writes.
        if (cfg_we) begin
            case (cfg_index)
                REG_SYNC:    sync_next    = cfg_wdata[VALUE_W-1:0];
                REG_DISABLE: disable_next = cfg_wdata[VALUE_W-1:0];
                REG_DIVIDER: divider_next = cfg_wdata[DIVIDER_W-1:0];
                default:     ;
            endcase
        end

        case (state_reg)
            // Take a request, decode it and update the narrow state at once.
            ST_IDLE: begin
                if (s_valid) begin
                    now_next    = s_data.now_seconds;
                    odd_next    = s_data.count_is_odd;
                    dvd_next    = CREDIT_W'(s_data.token_value) * CREDIT_W'(SECONDS_PER_DAY);
                    rem_next    = '0;
                    exp_lt_next = 1'b0;
                    cnt_next    = '0;
                    state_next  = ST_DIV;
                    case (s_data.action)
                        ACT_REJECT: begin
                            kind_next = KIND_REJECT;
                            fail_next = (fail_reg < FAIL_CAP) ? fail_reg + 1'b1 : FAIL_CAP;
                        end
                        ACT_ACCEPT: begin
                            fail_next = '0;
                            if (s_data.token_value == sync_reg) begin
                                kind_next = KIND_SYNC;
                            end else if (s_data.token_value == disable_reg) begin
                                kind_next  = KIND_DISABLE;
                                meter_next = 1'b0;
                            end else begin
                                kind_next  = KIND_CREDIT;
                                meter_next = 1'b1;
                            end
                        end
                        default: begin
                            kind_next = KIND_QUERY;
                        end
                    endcase
                end
            end

            // One quotient bit per cycle; the first passes also compare expiry with now.
            ST_DIV: begin
                rem_next = trial_ge ? DIVIDER_W'(trial - {1'b0, divisor})
                                    : trial[DIVIDER_W-1:0];
                dvd_next = {dvd_reg[CREDIT_W-2:0], trial_ge};
                if (cnt_reg < CNT_W'(NUM_DIGITS)) begin
                    exp_lt_next = (exp_d < now_d) | ((exp_d == now_d) & exp_lt_reg);
                    now_next    = {now_d, now_reg[TIME_W-1:DIGIT_W]};
                    expiry_next = {exp_d, expiry_reg[TIME_W-1:DIGIT_W]};
                end
                if (cnt_reg == CNT_W'(CREDIT_W - 1)) begin
                    cnt_next     = '0;
                    carry_next   = 1'b0;
                    exp_gt_next  = 1'b0;
                    lock_gt_next = 1'b0;
                    state_next   = ST_ADD;
                    if (kind_reg == KIND_REJECT) begin
                        addend_next = lock_addend;
                    end else if (kind_reg == KIND_CREDIT) begin
                        addend_next = TIME_W'(dvd_next);
                    end else begin
                        addend_next = '0;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // One digit per cycle: add, then compare the new times with now.
            ST_ADD: begin
                carry_next   = sum_d[DIGIT_W];
                exp_gt_next  = (new_exp_d > now_d) | ((new_exp_d == now_d) & exp_gt_reg);
                lock_gt_next = (new_lock_d > now_d) | ((new_lock_d == now_d) & lock_gt_reg);
                now_next     = {now_d, now_reg[TIME_W-1:DIGIT_W]};
                expiry_next  = {new_exp_d, expiry_reg[TIME_W-1:DIGIT_W]};
                lock_next    = {new_lock_d, lock_reg[TIME_W-1:DIGIT_W]};
                addend_next  = {{DIGIT_W{1'b0}}, addend_reg[TIME_W-1:DIGIT_W]};
                if (cnt_reg == CNT_W'(NUM_DIGITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Hand the result over once the output register is free.
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.active         = ~meter_reg | exp_gt_reg;
                    m_data_next.entry_allowed  = ~lock_gt_reg;
                    m_data_next.failure_level  = fail_reg;
                    m_data_next.store_request  = 1'b1;
                    case (kind_reg)
                        KIND_SYNC:    m_data_next.blink_count = BLINK_SYNC;
                        KIND_DISABLE: m_data_next.blink_count = BLINK_DISABLE;
                        KIND_CREDIT:  m_data_next.blink_count = BLINK_CREDIT;
                        default: begin
                            m_data_next.blink_count   = BLINK_NONE;
                            m_data_next.store_request = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/pat_checker.sv
module pat_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input pat_pkg::pat_out_t m_data
);
    import pat_pkg::*;

    // A stalled result keeps its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // The failure count stays capped.
    a_fail_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.failure_level <= FAIL_CAP)
        else $error("failure level above cap");

    // Only the defined blink codes appear, and a store goes with every blink.
    a_blink_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.blink_count == BLINK_NONE && !m_data.store_request) ||
                     (m_data.store_request && (m_data.blink_count == BLINK_CREDIT ||
                      m_data.blink_count == BLINK_SYNC || m_data.blink_count == BLINK_DISABLE))))
        else $error("bad blink or store combination");

    // A new request is never taken in the cycle right after one was accepted.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

endmodule

bind prepaid_activation_timer pat_checker u_pat_checker (.*);
